/* hdl/particle_update_step_assert.svh */
// assertion macros for the particle update pipeline
`ifndef PARTICLE_UPDATE_STEP_ASSERT_SVH
`define PARTICLE_UPDATE_STEP_ASSERT_SVH

// same-cycle implication, off during reset
`define PU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pu_pkg.sv */
package pu_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_FRAME_TIME  = 3'd0;
  localparam logic [2:0] REG_START_COLOR = 3'd1;
  localparam logic [2:0] REG_END_COLOR   = 3'd2;
  localparam logic [2:0] REG_START_SIZE  = 3'd3;
  localparam logic [2:0] REG_END_SIZE    = 3'd4;
  localparam logic [2:0] REG_FADE        = 3'd5;
  localparam logic [2:0] REG_FLICKER     = 3'd6;

  // register reset values
  localparam logic [15:0] FRAME_TIME_RST  = 16'd1092;
  localparam logic [31:0] START_COLOR_RST = 32'hFFFF_FFFF;

  // arithmetic constants
  localparam logic [23:0] LIFE_MIN      = 24'd3277;
  localparam logic [23:0] AGE_MAX       = 24'hFF_FFFF;
  localparam logic [16:0] FRICTION      = 17'd64225;
  localparam logic [17:0] FLICKER_TURNS = 18'd208608;
  localparam logic [32:0] BHASKARA_K    = 33'h1_4000_0000;
  localparam logic [16:0] HALF_Q16      = 17'd32768;

  typedef struct packed {
    logic [23:0]        age;
    logic [23:0]        lifetime;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } pu_in_t;

  typedef struct packed {
    logic               expired;
    logic [23:0]        new_age;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [23:0]        color_rgb;
    logic [7:0]         alpha;
    logic signed [15:0] heading;
  } pu_out_t;

  typedef struct packed {
    logic [15:0] frame_time;
    logic [31:0] start_color;
    logic [31:0] end_color;
    logic [31:0] start_size;
    logic [31:0] end_size;
    logic        fade_enable;
    logic        flicker_enable;
  } pu_cfg_t;

  // everything one particle carries down the pipeline
  typedef struct packed {
    logic               exp;
    logic [23:0]        na;
    logic [23:0]        life;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [48:0] pvx;
    logic signed [48:0] pvy;
    logic signed [48:0] vdx;
    logic signed [48:0] vdy;
    logic signed [31:0] nvx;
    logic signed [31:0] nvy;
    logic [15:0]        phase;
    logic [23:0]        t_rem;
    logic [15:0]        t_q;
    logic [28:0]        w;
    logic [32:0]        s_den;
    logic [32:0]        s_rem;
    logic [16:0]        s_q;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic [15:0]        cz;
    logic               czero;
    logic [15:0]        sw;
    logic [15:0]        sh;
    logic [7:0]         cr;
    logic [7:0]         cg;
    logic [7:0]         cb;
    logic [7:0]         ca;
  } pu_pipe_t;

  // arctangent of 2^-i in pi/32768 units
  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:  v = 16'd8192;
      4'd1:  v = 16'd4836;
      4'd2:  v = 16'd2555;
      4'd3:  v = 16'd1297;
      4'd4:  v = 16'd651;
      4'd5:  v = 16'd326;
      4'd6:  v = 16'd163;
      4'd7:  v = 16'd81;
      4'd8:  v = 16'd41;
      4'd9:  v = 16'd20;
      4'd10: v = 16'd10;
      4'd11: v = 16'd5;
      4'd12: v = 16'd3;
      4'd13: v = 16'd1;
      4'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // a + floor((b - a) * t / 2^16), modulo 2^16
  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] t);
    logic signed [16:0] d;
    logic signed [33:0] p;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, t});
    return a + p[31:16];
  endfunction

endpackage

/* hdl/pu_cfg_regs.sv */
module pu_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output pu_pkg::pu_cfg_t                cfg
);
  import pu_pkg::*;

  pu_cfg_t    cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_time     <= FRAME_TIME_RST;
      cfg_r.start_color    <= START_COLOR_RST;
      cfg_r.end_color      <= '0;
      cfg_r.start_size     <= '0;
      cfg_r.end_size       <= '0;
      cfg_r.fade_enable    <= 1'b1;
      cfg_r.flicker_enable <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_TIME:  cfg_r.frame_time     <= pwdata[15:0];
        REG_START_COLOR: cfg_r.start_color    <= pwdata;
        REG_END_COLOR:   cfg_r.end_color      <= pwdata;
        REG_START_SIZE:  cfg_r.start_size     <= pwdata;
        REG_END_SIZE:    cfg_r.end_size       <= pwdata;
        REG_FADE:        cfg_r.fade_enable    <= pwdata[0];
        REG_FLICKER:     cfg_r.flicker_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_FRAME_TIME:  prdata = {16'b0, cfg_r.frame_time};
      REG_START_COLOR: prdata = cfg_r.start_color;
      REG_END_COLOR:   prdata = cfg_r.end_color;
      REG_START_SIZE:  prdata = cfg_r.start_size;
      REG_END_SIZE:    prdata = cfg_r.end_size;
      REG_FADE:        prdata = {31'b0, cfg_r.fade_enable};
      REG_FLICKER:     prdata = {31'b0, cfg_r.flicker_enable};
      default:         prdata = '0;
    endcase
  end

endmodule

/* hdl/particle_update_step.sv */
// One particle per transaction, one transaction per cycle while the result side is not
// stalled. Stage 1 ages the particle and forms the velocity products, stage 2 moves it,
// stages 3-10 run the age/lifetime restoring divider two quotient bits a stage,
// stages 4-11 run the 16 CORDIC iterations for the heading two a stage, stages 5-13
// the 17-bit flicker sine divider, and stage 14 is the output register that applies
// flicker to alpha. A stall on a valid result freezes the whole pipeline and shows
// on in_stall in the same cycle; bubbles are not squeezed out.
`include "particle_update_step_assert.svh"

module particle_update_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pu_pkg::pu_in_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pu_pkg::pu_out_t                out_data
);
  import pu_pkg::*;

  localparam int NSTG = 13;

  pu_cfg_t   cfg;
  pu_pipe_t  stg_r   [1:NSTG];
  pu_pipe_t  stg_nxt [1:NSTG];
  logic [NSTG:1] vld_r;
  pu_out_t   out_r;
  pu_out_t   out_nxt;
  logic      out_vld_r;
  logic      en;

  pu_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // global advance: the result register is the only place a stall bites
  assign in_stall  = out_vld_r && out_stall;
  assign en        = !in_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // stage 1: age, expiry and velocity products
  always_comb begin
    logic [24:0] asum;
    logic [23:0] life;
    stg_nxt[1] = '0;
    asum = {1'b0, in_data.age} + {9'b0, cfg.frame_time};
    life = (in_data.lifetime < LIFE_MIN) ? LIFE_MIN : in_data.lifetime;
    stg_nxt[1].na   = asum[24] ? AGE_MAX : asum[23:0];
    stg_nxt[1].life = life;
    stg_nxt[1].exp  = (stg_nxt[1].na >= life);
    stg_nxt[1].px   = in_data.pos_x;
    stg_nxt[1].py   = in_data.pos_y;
    stg_nxt[1].pvx  = in_data.vel_x * $signed({1'b0, cfg.frame_time});
    stg_nxt[1].pvy  = in_data.vel_y * $signed({1'b0, cfg.frame_time});
    stg_nxt[1].vdx  = in_data.vel_x * $signed(FRICTION);
    stg_nxt[1].vdy  = in_data.vel_y * $signed(FRICTION);
  end

  // stages 2 to 13
  for (genvar k = 2; k <= NSTG; k++) begin : g_stage
    always_comb begin
      pu_pipe_t           p;
      logic [41:0]        ph;
      logic [30:0]        wp;
      logic [24:0]        trem2;
      logic [33:0]        srem2;
      logic signed [35:0] xs;
      logic signed [35:0] ys;
      logic signed [35:0] ox;
      logic [3:0]         it;
      p = stg_r[k-1];
      ph = '0;
      wp = '0;
      trem2 = '0;
      srem2 = '0;
      xs = '0;
      ys = '0;
      ox = '0;
      it = '0;

      // move, damp, flicker phase, divider seed
      if (k == 2) begin
        p.px    = p.px + p.pvx[47:16];
        p.py    = p.py + p.pvy[47:16];
        p.nvx   = p.vdx[47:16];
        p.nvy   = p.vdy[47:16];
        ph      = 42'(p.na) * 42'(FLICKER_TURNS);
        p.phase = ph[31:16];
        p.t_rem = p.na;
        p.t_q   = '0;
      end

      // sine numerator term and fold into the right half plane
      if (k == 3) begin
        wp  = 31'(p.phase[14:0]) * 31'(16'd32768 - {1'b0, p.phase[14:0]});
        p.w = wp[28:0];
        p.czero = (p.nvx == 0) && (p.nvy == 0);
        p.cx = 36'(p.nvx);
        p.cy = 36'(p.nvy);
        p.cz = '0;
        if (p.nvx < 0) begin
          ox = p.cx;
          if (p.nvy >= 0) begin
            p.cx = p.cy;
            p.cy = -ox;
            p.cz = 16'd16384;
          end else begin
            p.cx = -p.cy;
            p.cy = ox;
            p.cz = 16'hC000;
          end
        end
      end

      // age / lifetime, two quotient bits
      if (k >= 3 && k <= 10) begin
        for (int j = 0; j < 2; j++) begin
          trem2 = {p.t_rem, 1'b0};
          if (trem2 >= {1'b0, p.life}) begin
            trem2   = trem2 - {1'b0, p.life};
            p.t_q   = {p.t_q[14:0], 1'b1};
          end else begin
            p.t_q   = {p.t_q[14:0], 1'b0};
          end
          p.t_rem = trem2[23:0];
        end
      end

      // sine divider seed
      if (k == 4) begin
        p.s_den = BHASKARA_K - {2'b0, p.w, 2'b0};
        p.s_rem = {1'b0, p.w, 3'b0};
        p.s_q   = '0;
      end

      // cordic vectoring, two iterations
      if (k >= 4 && k <= 11) begin
        for (int j = 0; j < 2; j++) begin
          it = 4'(2 * (k - 4) + j);
          xs = p.cx >>> it;
          ys = p.cy >>> it;
          if (!p.cy[35]) begin
            p.cx = p.cx + ys;
            p.cy = p.cy - xs;
            p.cz = p.cz + atan_entry(it);
          end else begin
            p.cx = p.cx - ys;
            p.cy = p.cy + xs;
            p.cz = p.cz - atan_entry(it);
          end
        end
      end

      // sine divider, one bit in the first stage then two
      if (k >= 5) begin
        for (int j = 0; j < 2; j++) begin
          if (k > 5 || j == 0) begin
            srem2 = {p.s_rem, 1'b0};
            if (srem2 >= {1'b0, p.s_den}) begin
              srem2 = srem2 - {1'b0, p.s_den};
              p.s_q = {p.s_q[15:0], 1'b1};
            end else begin
              p.s_q = {p.s_q[15:0], 1'b0};
            end
            p.s_rem = srem2[32:0];
          end
        end
      end

      // size and colour interpolation
      if (k == 11) begin
        p.sw = lerp16(cfg.start_size[31:16], cfg.end_size[31:16], p.t_q);
        p.sh = lerp16(cfg.start_size[15:0], cfg.end_size[15:0], p.t_q);
        p.cr = 8'(lerp16({8'b0, cfg.start_color[31:24]}, {8'b0, cfg.end_color[31:24]}, p.t_q));
        p.cg = 8'(lerp16({8'b0, cfg.start_color[23:16]}, {8'b0, cfg.end_color[23:16]}, p.t_q));
        p.cb = 8'(lerp16({8'b0, cfg.start_color[15:8]}, {8'b0, cfg.end_color[15:8]}, p.t_q));
        if (cfg.fade_enable) begin
          p.ca = 8'(lerp16({8'b0, cfg.start_color[7:0]}, {8'b0, cfg.end_color[7:0]}, p.t_q));
        end else begin
          p.ca = cfg.start_color[7:0];
        end
      end

      stg_nxt[k] = p;
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= NSTG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:1], in_valid};
    end
  end

  // final stage: flicker and result assembly
  always_comb begin
    pu_pipe_t    p;
    logic [16:0] f;
    logic [24:0] am;
    p = stg_r[NSTG];
    f = p.phase[15] ? (HALF_Q16 - {1'b0, p.s_q[16:1]})
                    : (HALF_Q16 + {1'b0, p.s_q[16:1]});
    am = 25'(p.ca) * 25'(f);
    out_nxt = '0;
    if (p.exp) begin
      out_nxt.expired = 1'b1;
    end else begin
      out_nxt.new_age   = p.na;
      out_nxt.new_pos_x = p.px;
      out_nxt.new_pos_y = p.py;
      out_nxt.new_vel_x = p.nvx;
      out_nxt.new_vel_y = p.nvy;
      out_nxt.width     = p.sw;
      out_nxt.height    = p.sh;
      out_nxt.color_rgb = {p.cr, p.cg, p.cb};
      out_nxt.alpha     = cfg.flicker_enable ? am[23:16] : p.ca;
      out_nxt.heading   = p.czero ? 16'sd0 : $signed(p.cz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NSTG];
    end
  end

  // checks
  `PU_ASSERT_NOW(a_t_seed, vld_r[2] && !stg_r[2].exp, stg_r[2].t_rem < stg_r[2].life, "age seed not below lifetime")
  `PU_ASSERT_NOW(a_s_seed, vld_r[4], stg_r[4].s_rem < stg_r[4].s_den, "sine seed not below divisor")
  `PU_ASSERT_NXT(a_advance, vld_r[NSTG] && !in_stall, out_valid, "finished transaction dropped")
  `PU_ASSERT_NOW(a_expired_zero, out_valid && out_data.expired, out_data.new_age == 0 && out_data.alpha == 0, "expired result not cleared")

endmodule
